### rtl/core/spe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spe_pkg;

    localparam int PORT_MAX = 16;
    localparam int MATCH_W = 4;

    localparam logic [MATCH_W-1:0] UNLOCK_LEN = 4'd14;
    localparam logic [MATCH_W-1:0] UNLOCK_LAST = 4'd13;

    localparam logic [7:0] SIGNAL_CODE = 8'hFF;
    localparam logic [7:0] LOCK_CODE = 8'h80;

    localparam int BIT_OUTPUT = 6;
    localparam int BIT_PULLUP = 5;
    localparam int BIT_LEVEL = 4;

    typedef struct packed {
        logic [7:0]          reply_byte;
        logic [PORT_MAX-1:0] direction_mask;
        logic [PORT_MAX-1:0] drive_mask;
        logic                expander_active;
    } spe_result_t;

    // Unlock string, terminating zero byte included.
    function automatic logic [7:0] unlock_byte(input logic [MATCH_W-1:0] pos);
        logic [7:0] b;
        case (pos)
            4'd0:    b = 8'h4F;  // O
            4'd1:    b = 8'h50;  // P
            4'd2:    b = 8'h44;  // D
            4'd3:    b = 8'h49;  // I
            4'd4:    b = 8'h44;  // D
            4'd5:    b = 8'h47;  // G
            4'd6:    b = 8'h42;  // B
            4'd7:    b = 8'h50;  // P
            4'd8:    b = 8'h45;  // E
            4'd9:    b = 8'h49;  // I
            4'd10:   b = 8'h4E;  // N
            4'd11:   b = 8'h49;  // I
            4'd12:   b = 8'h54;  // T
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

### rtl/core/spe_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface spe_cmd_if;
    logic        valid;
    logic        ready;
    logic [7:0]  rx_byte;
    logic [15:0] pin_levels;

    modport source (output valid, output rx_byte, output pin_levels, input ready);
    modport sink (input valid, input rx_byte, input pin_levels, output ready);
endinterface

interface spe_reply_if;
    logic        valid;
    logic        ready;
    logic [7:0]  reply_byte;
    logic [15:0] direction_mask;
    logic [15:0] drive_mask;
    logic        expander_active;

    modport source (output valid, output reply_byte, output direction_mask,
                    output drive_mask, output expander_active, input ready);
    modport sink (input valid, input reply_byte, input direction_mask,
                  input drive_mask, input expander_active, output ready);
endinterface

`default_nettype wire

### rtl/core/spe_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module spe_decode
    import spe_pkg::*;
#(
    parameter int PORT_COUNT = 16
)
(
    input  wire logic [7:0]            rx_byte,
    input  wire logic [15:0]           pin_levels,
    input  wire logic                  unlocked,
    input  wire logic [MATCH_W-1:0]    match_pos,
    input  wire logic [PORT_COUNT-1:0] direction,
    input  wire logic [PORT_COUNT-1:0] drive,
    output logic                       unlocked_next,
    output logic [MATCH_W-1:0]         match_pos_next,
    output logic [PORT_COUNT-1:0]      direction_next,
    output logic [PORT_COUNT-1:0]      drive_next,
    output logic                       emit,
    output spe_result_t                result
);

    logic                  is_out;
    logic                  is_pull;
    logic                  level;
    logic [3:0]            port;
    logic [PORT_COUNT-1:0] sel;
    logic                  pin;
    logic [7:0]            reply;

    assign is_out = rx_byte[BIT_OUTPUT];
    assign is_pull = rx_byte[BIT_PULLUP];
    assign level = rx_byte[BIT_LEVEL];
    assign port = rx_byte[3:0];

    // One-hot port select; stays zero for a port number of PORT_COUNT or above.
    always_comb
    begin
        for (int i = 0; i < PORT_COUNT; i++)
        begin
            sel[i] = (port == 4'(i));
        end
    end

    assign pin = |(pin_levels[PORT_COUNT-1:0] & sel);

    always_comb
    begin
        unlocked_next = unlocked;
        match_pos_next = match_pos;
        direction_next = direction;
        drive_next = drive;
        emit = 1'b0;
        reply = SIGNAL_CODE;

        if (!unlocked)
        begin
            if (match_pos < UNLOCK_LEN && rx_byte == unlock_byte(match_pos))
            begin
                match_pos_next = match_pos + 4'd1;
                if (match_pos == UNLOCK_LAST)
                begin
                    unlocked_next = 1'b1;
                    emit = 1'b1;
                end
            end
            else
            begin
                match_pos_next = '0;
            end
        end
        else if (rx_byte == SIGNAL_CODE)
        begin
            emit = 1'b1;
        end
        else if (rx_byte == LOCK_CODE)
        begin
            unlocked_next = 1'b0;
            match_pos_next = '0;
            emit = 1'b1;
        end
        else if (is_out && is_pull)
        begin
            emit = 1'b1;
        end
        else if (is_out)
        begin
            direction_next = direction | sel;
            drive_next = level ? (drive | sel) : (drive & ~sel);
            reply = rx_byte;
            emit = 1'b1;
        end
        else
        begin
            direction_next = direction & ~sel;
            drive_next = is_pull ? (drive | sel) : (drive & ~sel);
            reply = rx_byte;
            reply[BIT_LEVEL] = pin;
            emit = 1'b1;
        end
    end

    always_comb
    begin
        result.reply_byte = reply;
        result.direction_mask = PORT_MAX'(direction_next);
        result.drive_mask = PORT_MAX'(drive_next);
        result.expander_active = unlocked_next;
    end

endmodule

`default_nettype wire

### rtl/core/spe_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module spe_out_stage
    import spe_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         load,
    input  wire spe_result_t  result,
    output logic              space,
    spe_reply_if.source       rsp
);

    logic        valid_reg;
    logic        valid_next;
    spe_result_t data_reg;

    // The register can take a new reply in the same cycle the old one leaves.
    assign space = !valid_reg || rsp.ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign rsp.valid = valid_reg;
    assign rsp.reply_byte = data_reg.reply_byte;
    assign rsp.direction_mask = data_reg.direction_mask;
    assign rsp.drive_mask = data_reg.drive_mask;
    assign rsp.expander_active = data_reg.expander_active;

endmodule

`default_nettype wire

### rtl/core/serial_port_expander_command.sv
// Command decoder for a serial port expander. Each cmd transaction carries one
// received byte and the sampled pin levels; the block stays locked until it
// has seen the unlock string "OPDIDGBPEINIT" and its zero byte, then answers
// test, lock and port commands and keeps the direction and drive bits of
// PORT_COUNT ports. A byte that causes a reply shows it on rsp in the cycle after
// the transaction; bytes that only advance the unlock match give no reply. The
// decode sits between the state registers and a single reply register, and a
// new byte is taken every cycle as long as the reply register is empty or
// being read in that cycle, so the sustained rate is one byte per cycle.
`timescale 1ns / 1ps
`default_nettype none

module serial_port_expander_command
    import spe_pkg::*;
#(
    parameter int PORT_COUNT = 16
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    spe_cmd_if.sink     cmd,
    spe_reply_if.source rsp
);

    logic                  unlocked_reg;
    logic                  unlocked_next;
    logic [MATCH_W-1:0]    match_pos_reg;
    logic [MATCH_W-1:0]    match_pos_next;
    logic [PORT_COUNT-1:0] direction_reg;
    logic [PORT_COUNT-1:0] direction_next;
    logic [PORT_COUNT-1:0] drive_reg;
    logic [PORT_COUNT-1:0] drive_next;
    logic                  emit;
    logic                  space;
    logic                  accept;
    spe_result_t           result;

    assign cmd.ready = space;
    assign accept = cmd.valid && space;

    spe_decode #(
        .PORT_COUNT(PORT_COUNT)
    ) u_decode (
        .rx_byte        (cmd.rx_byte),
        .pin_levels     (cmd.pin_levels),
        .unlocked       (unlocked_reg),
        .match_pos      (match_pos_reg),
        .direction      (direction_reg),
        .drive          (drive_reg),
        .unlocked_next  (unlocked_next),
        .match_pos_next (match_pos_next),
        .direction_next (direction_next),
        .drive_next     (drive_next),
        .emit           (emit),
        .result         (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unlocked_reg <= 1'b0;
            match_pos_reg <= '0;
            direction_reg <= '0;
            drive_reg <= '0;
        end
        else if (accept)
        begin
            unlocked_reg <= unlocked_next;
            match_pos_reg <= match_pos_next;
            direction_reg <= direction_next;
            drive_reg <= drive_next;
        end
    end

    spe_out_stage u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (accept && emit),
        .result (result),
        .space  (space),
        .rsp    (rsp)
    );

    // While locked the match position never runs past the last unlock byte.
    a_match_range: assert property (@(posedge clk) disable iff (!rst_n)
        !unlocked_reg |-> match_pos_reg <= UNLOCK_LAST)
        else $error("unlock match position out of range");

    // A locked block replies only on the final unlock byte.
    a_locked_reply: assert property (@(posedge clk) disable iff (!rst_n)
        accept && emit && !unlocked_reg |-> match_pos_reg == UNLOCK_LAST)
        else $error("reply while locked before the unlock string completed");

    // Only an accepted lock command locks the block again.
    a_relock: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(unlocked_reg) |-> $past(accept && cmd.rx_byte == LOCK_CODE))
        else $error("block locked without a lock command");

    // Port state cannot change while the block is locked.
    a_locked_ports: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!unlocked_reg) |-> $stable(direction_reg) && $stable(drive_reg))
        else $error("port state changed while locked");

endmodule

`default_nettype wire
